@@ rtl/lzss_decompressor_assert.svh @@
// Assertion macros used by the decompressor top level.
`ifndef LZSS_DECOMPRESSOR_ASSERT_SVH
`define LZSS_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LZD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzd assertion failed");

// Next-cycle implication, checked outside reset.
`define LZD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzd assertion failed");

`endif

@@ rtl/lzd_pkg.sv @@
// Types and constants shared by the decompressor modules.
`default_nettype none
package lzd_pkg;

  localparam int THRESHOLD = 2;
  localparam int LEN_W     = 5;
  localparam int POS_W     = 12;
  localparam logic [7:0] FILL_CHAR = 8'h20;

  // Token decoded from an accepted input word.
  typedef struct packed {
    logic             lit;
    logic             copy;
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } lzd_cmd_t;

  // Copy engine status seen by the input handshake.
  typedef struct packed {
    logic busy;
    logic room;
  } lzd_eng_status_t;

endpackage
`default_nettype wire

@@ rtl/lzd_in_if.sv @@
// Compressed-stream input channel.
`default_nettype none
interface lzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source(output valid, output in_byte, input ready);
  modport sink(input valid, input in_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/lzd_out_if.sv @@
// Decompressed-byte output channel.
`default_nettype none
interface lzd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source(output valid, output out_byte, output run_last, input ready);
  modport sink(input valid, input out_byte, input run_last, output ready);
endinterface
`default_nettype wire

@@ rtl/lzd_ring.sv @@
// History ring: one write port, one registered read port, clearing sweep after reset.
`default_nettype none
module lzd_ring import lzd_pkg::*; #(
  parameter int WINDOW_SIZE = 4096,
  parameter int MAX_MATCH   = 18,
  localparam int AW = $clog2(WINDOW_SIZE)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data,
  output logic               clearing
);

  logic [7:0]    mem [WINDOW_SIZE];
  logic [AW-1:0] clr_idx;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;

  always_comb begin
    if (clearing) begin
      we = 1'b1;
      wa = clr_idx;
      wd = (32'(clr_idx) < 32'(WINDOW_SIZE - MAX_MATCH)) ? FILL_CHAR : 8'h00;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == AW'(WINDOW_SIZE - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ rtl/lzd_parser.sv @@
// Token parser: flag byte, literals and the two bytes of a pair.
`default_nettype none
module lzd_parser import lzd_pkg::*; #(
  parameter int MAX_MATCH = 18
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  output lzd_cmd_t        cmd,
  output logic            lit_due
);

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_HIGH
  } phase_t;

  phase_t           phase;
  logic [8:0]       flag_shift;
  logic [7:0]       offset_low;
  logic [8:0]       flag_next;
  logic [LEN_W-1:0] len_raw;

  assign flag_next = flag_shift >> 1;
  assign lit_due   = (phase == PH_TOKEN) && flag_shift[0];
  assign len_raw   = LEN_W'(in_byte[3:0]) + LEN_W'(THRESHOLD + 1);

  always_comb begin
    cmd.lit  = accept && lit_due;
    cmd.copy = accept && (phase == PH_HIGH);
    cmd.data = in_byte;
    cmd.pos  = {in_byte[7:4], offset_low};
    cmd.len  = (len_raw > LEN_W'(MAX_MATCH)) ? LEN_W'(MAX_MATCH) : len_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FLAG;
      flag_shift <= '0;
      offset_low <= '0;
    end else if (accept) begin
      case (phase)
        PH_TOKEN: begin
          if (flag_shift[0]) begin
            flag_shift <= flag_next;
            phase      <= (flag_next <= 9'd1) ? PH_FLAG : PH_TOKEN;
          end else begin
            offset_low <= in_byte;
            phase      <= PH_HIGH;
          end
        end
        PH_HIGH: begin
          flag_shift <= flag_next;
          phase      <= (flag_next <= 9'd1) ? PH_FLAG : PH_TOKEN;
        end
        default: begin
          flag_shift <= {1'b1, in_byte};
          phase      <= PH_TOKEN;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/lzd_engine.sv @@
// Copy engine: ring read/write sequencing, forwarding and output register.
`default_nettype none
module lzd_engine import lzd_pkg::*; #(
  parameter int WINDOW_SIZE = 4096,
  parameter int MAX_MATCH   = 18,
  localparam int AW = $clog2(WINDOW_SIZE)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lzd_cmd_t      cmd,
  lzd_out_if.source          dout,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  wire logic [7:0]    rd_data,
  output lzd_eng_status_t    status
);

  logic [AW-1:0]    wp;
  logic [AW-1:0]    wp_next;
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    rd_ptr_next;
  logic [LEN_W-1:0] rem;
  logic             pend;
  logic             pend_last;
  logic             hit;
  logic [7:0]       hit_byte;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_last;
  logic [7:0]       cur_byte;
  logic             room;
  logic             fire;
  logic             issue;
  logic [15:0]      pos_rem;

  // Fold the 12-bit position into the window by restoring subtraction.
  always_comb begin
    pos_rem = 16'(cmd.pos);
    for (int k = 3; k >= 0; k--) begin
      if (pos_rem >= 16'(WINDOW_SIZE << k)) pos_rem = pos_rem - 16'(WINDOW_SIZE << k);
    end
  end

  assign wp_next     = (wp == AW'(WINDOW_SIZE - 1)) ? '0 : wp + 1'b1;
  assign rd_ptr_next = (rd_ptr == AW'(WINDOW_SIZE - 1)) ? '0 : rd_ptr + 1'b1;

  // Take the byte written in the read's own cycle from the bypass.
  assign cur_byte = hit ? hit_byte : rd_data;
  assign room     = !out_valid || dout.ready;
  assign fire     = pend && room;
  assign issue    = (rem != '0) && (!pend || fire);

  assign wr_en   = fire || cmd.lit;
  assign wr_addr = wp;
  assign wr_data = fire ? cur_byte : cmd.data;
  assign rd_en   = issue;
  assign rd_addr = rd_ptr;

  assign status.busy = (rem != '0) || pend;
  assign status.room = room;

  assign dout.valid    = out_valid;
  assign dout.out_byte = out_byte;
  assign dout.run_last = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= AW'(WINDOW_SIZE - MAX_MATCH);
      rd_ptr    <= '0;
      rem       <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) wp <= wp_next;

      if (cmd.copy) begin
        rd_ptr <= pos_rem[AW-1:0];
        rem    <= cmd.len;
      end else if (issue) begin
        rd_ptr <= rd_ptr_next;
        rem    <= rem - 1'b1;
      end

      if (issue) begin
        pend      <= 1'b1;
        pend_last <= (rem == LEN_W'(1));
        hit       <= fire && (rd_ptr == wp);
        hit_byte  <= cur_byte;
      end else if (fire) begin
        pend <= 1'b0;
      end

      if (fire) begin
        out_valid <= 1'b1;
        out_byte  <= cur_byte;
        out_last  <= pend_last;
      end else if (cmd.lit) begin
        out_valid <= 1'b1;
        out_byte  <= cmd.data;
        out_last  <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/lzss_decompressor.sv @@
// LZSS decompressor top level: 4096-byte window, flag-byte token stream.
// Input din carries one compressed byte per word; output dout carries one
// decompressed byte per word, with run_last set on the final byte produced
// by a given input word. Both use valid/ready; a word moves when both are high.
// Flag bytes and pair low bytes produce no output. A literal appears on dout
// in the cycle after it is accepted. A pair high byte starts a copy of
// 3..MAX_MATCH bytes; the first byte passes the copy counter, the ring read
// register and the output register, and the rest follow one per cycle while
// dout is ready, as each byte takes one read and one write of the
// single-port-pair ring memory. A pair holds din off until its copy is done.
// After reset the ring is filled with its initial contents, one entry per
// cycle, over all WINDOW_SIZE (4096) entries; din stays not ready then.
// When dout stalls, the copy freezes with its byte held in the output
// register; din keeps taking flag and pair bytes while a literal waits.
`default_nettype none
`include "lzss_decompressor_assert.svh"
module lzss_decompressor import lzd_pkg::*; #(
  parameter int WINDOW_SIZE = 4096,
  parameter int MAX_MATCH   = 18,
  localparam int AW = $clog2(WINDOW_SIZE)
) (
  input  wire logic clk,
  input  wire logic rst,
  lzd_in_if.sink    din,
  lzd_out_if.source dout
);

  lzd_cmd_t        cmd;
  lzd_eng_status_t st;
  logic            lit_due;
  logic            clearing;
  logic            accept;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      rd_data;

  assign din.ready = !clearing && !st.busy && (!lit_due || st.room);
  assign accept    = din.valid && din.ready;

  lzd_parser #(
    .MAX_MATCH(MAX_MATCH)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (din.in_byte),
    .cmd     (cmd),
    .lit_due (lit_due)
  );

  lzd_engine #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .MAX_MATCH  (MAX_MATCH)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .dout    (dout),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .status  (st)
  );

  lzd_ring #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .MAX_MATCH  (MAX_MATCH)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  `LZD_ASSERT_NEXT(a_clear_once, clk, rst, !clearing, !clearing)
  `LZD_ASSERT_IMP(a_no_accept_busy, clk, rst, st.busy, !din.ready)
  `LZD_ASSERT_NEXT(a_copy_starts, clk, rst, cmd.copy, st.busy)

endmodule
`default_nettype wire

@@ verif/lzss_decompressor_tb.sv @@
// Self-checking testbench for the LZSS decompressor: random token streams, predicted output bytes.
`default_nettype none
module lzss_decompressor_tb import lzd_pkg::*;;

  localparam int RING_SIZE = 4096;
  localparam int MATCH_MAX = 18;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int STREAM_TARGET = 350;

  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_HIGH  = 2'd2
  } parse_ph_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lzd_in_if  in_ch();
  lzd_out_if out_ch();

  lzss_decompressor dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compressed stream waiting to be sent, and decoded bytes still owed by the block.
  logic [7:0] stream_q[$];
  dec_byte_t  decoded_q[$];

  int total_items = 0;
  int sent_cnt    = 0;
  int err_cnt     = 0;
  int cyc_cnt     = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  int hold_left   = 0;
  bit pressure_done = 1'b0;
  logic quiet;

  // Shadow decoder state.
  logic [7:0]  hist [RING_SIZE];
  logic [11:0] hist_wp;
  logic [8:0]  flags;
  parse_ph_t   phase;
  logic [7:0]  low_pos;

  // Generator-side write pointer, used to aim pairs at recent history.
  logic [11:0] gen_wp;

  assign quiet = (sent_cnt + 60 >= total_items) || (sent_cnt >= 200 && sent_cnt < 240);

  function automatic void hist_put(logic [7:0] b);
    hist[hist_wp] = b;
    hist_wp = hist_wp + 12'd1;
  endfunction

  function automatic void token_done();
    flags = flags >> 1;
    phase = (flags <= 9'd1) ? PH_FLAG : PH_TOKEN;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    logic [11:0] src;
    logic [7:0]  c;
    int          n;
    dec_byte_t   r;
    case (phase)
      PH_TOKEN: begin
        if (flags[0]) begin
          hist_put(b);
          r.data = b;
          r.last = 1'b1;
          decoded_q.push_back(r);
          token_done();
        end else begin
          low_pos = b;
          phase = PH_HIGH;
        end
      end
      PH_HIGH: begin
        src = {b[7:4], low_pos};
        n = int'(b[3:0]) + THRESHOLD + 1;
        if (n > MATCH_MAX) n = MATCH_MAX;
        for (int k = 0; k < n; k++) begin
          c = hist[src + 12'(k)];
          hist_put(c);
          r.data = c;
          r.last = (k == n - 1);
          decoded_q.push_back(r);
        end
        token_done();
      end
      default: begin
        flags = {1'b1, b};
        phase = PH_TOKEN;
      end
    endcase
  endfunction

  task automatic add_lit(logic [7:0] b);
    stream_q.push_back(b);
    gen_wp = gen_wp + 12'd1;
  endtask

  task automatic add_pair(logic [11:0] pos, logic [3:0] code);
    stream_q.push_back(pos[7:0]);
    stream_q.push_back({pos[11:8], code});
    gen_wp = gen_wp + 12'(code) + 12'(THRESHOLD + 1);
  endtask

  initial begin
    logic [7:0]  f;
    logic [11:0] pos;
    int          sel;
    gen_wp = 12'(RING_SIZE - MATCH_MAX);

    // Directed group: pairs into the space fill and the zero tail, an overlapping
    // run, a read at the write pointer itself, then literal extremes.
    stream_q.push_back(8'hF0);
    add_pair(12'h000, 4'd0);
    add_pair(12'hFFF, 4'd15);
    add_pair(gen_wp - 12'd1, 4'd15);
    add_pair(gen_wp, 4'd4);
    add_lit(8'h00);
    add_lit(8'hFF);
    add_lit(8'h5A);
    add_lit(8'hA5);

    while (stream_q.size() < STREAM_TARGET) begin
      f = 8'($urandom_range(0, 255));
      stream_q.push_back(f);
      for (int i = 0; i < 8; i++) begin
        if (f[i]) begin
          add_lit(8'($urandom_range(0, 255)));
        end else begin
          sel = $urandom_range(0, 3);
          if (sel == 0) pos = 12'($urandom_range(0, RING_SIZE - 1));
          else if (sel == 3) pos = gen_wp - 12'($urandom_range(1, 300));
          else pos = gen_wp - 12'($urandom_range(1, 20));
          add_pair(pos, 4'($urandom_range(0, 15)));
        end
      end
    end

    // End on a pair whose high byte never comes.
    stream_q.push_back(8'h00);
    stream_q.push_back(8'($urandom_range(0, 255)));
    total_items = stream_q.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (sent_cnt == total_items && decoded_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Driver: hold a word until taken, insert gap bursts between words.
  always @(posedge clk) begin
    bit fire;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.in_byte <= 8'h00;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        void'(stream_q.pop_front());
        sent_cnt <= sent_cnt + 1;
      end
      if (!(in_ch.valid && !fire)) begin
        if (gap_left == 0 && !quiet && stream_q.size() > 0 && $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 17);
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (stream_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.in_byte <= stream_q[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back the block up.
  always @(posedge clk) begin
    logic nr;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      nr = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else if (!pressure_done && sent_cnt >= 120) begin
        hold_left = 400;
        pressure_done = 1'b1;
        nr = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nr = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        nr = 1'b0;
      end
      out_ch.ready <= nr;
    end
  end

  // Monitor: predict on each accepted input word, check each accepted output word.
  always @(posedge clk) begin
    dec_byte_t want;
    if (rst) begin
      for (int k = 0; k < RING_SIZE; k++)
        hist[k] = (k < RING_SIZE - MATCH_MAX) ? FILL_CHAR : 8'h00;
      hist_wp = 12'(RING_SIZE - MATCH_MAX);
      flags = 9'd0;
      phase = PH_FLAG;
      low_pos = 8'h00;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          if (err_cnt < 10)
            $display("unexpected output word: out_byte %02h run_last %0d",
                     out_ch.out_byte, out_ch.run_last);
          err_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.data || out_ch.run_last !== want.last) begin
            if (err_cnt < 10)
              $display("mismatch: out_byte exp %02h got %02h, run_last exp %0d got %0d",
                       want.data, out_ch.out_byte, want.last, out_ch.run_last);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
`default_nettype wire
